FILE: sv/cpc_pkg.sv
// Shared types, codes and constants of the cascaded position/current controller.
`default_nettype none

package cpc_pkg;

    localparam int TRACK_DEPTH_DEF   = 1024;
    localparam int TEST_SAMPLES_DEF  = 100;
    localparam int CURRENT_LIMIT_DEF = 400;
    localparam int DRIVE_LIMIT_DEF   = 100;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [31:0] KP_CURRENT_RST  = 32'd85197;
    localparam logic [31:0] KI_CURRENT_RST  = 32'd3932;
    localparam logic [31:0] KP_POSITION_RST = 32'd1769472;
    localparam logic [31:0] KI_POSITION_RST = 32'd655;
    localparam logic [31:0] KD_POSITION_RST = 32'd32768000;

    localparam logic [3:0] FUNC_CURRENT_TICK  = 4'd0;
    localparam logic [3:0] FUNC_POSITION_TICK = 4'd1;
    localparam logic [3:0] FUNC_IDLE          = 4'd2;
    localparam logic [3:0] FUNC_OPEN_LOOP     = 4'd3;
    localparam logic [3:0] FUNC_HOLD          = 4'd4;
    localparam logic [3:0] FUNC_TRACK         = 4'd5;
    localparam logic [3:0] FUNC_TEST          = 4'd6;
    localparam logic [3:0] FUNC_LOAD_TRACK    = 4'd7;
    localparam logic [3:0] FUNC_LOAD_WAVE     = 4'd8;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_OPEN  = 3'd1;
    localparam logic [2:0] MODE_HOLD  = 3'd2;
    localparam logic [2:0] MODE_TRACK = 3'd3;
    localparam logic [2:0] MODE_TEST  = 3'd4;

    localparam logic [2:0] REG_KP_CURRENT   = 3'd0;
    localparam logic [2:0] REG_KI_CURRENT   = 3'd1;
    localparam logic [2:0] REG_KP_POSITION  = 3'd2;
    localparam logic [2:0] REG_KI_POSITION  = 3'd3;
    localparam logic [2:0] REG_KD_POSITION  = 3'd4;
    localparam logic [2:0] REG_TRACK_LENGTH = 3'd5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CUR,
        OP_POS,
        OP_IDLE,
        OP_OPEN,
        OP_HOLD,
        OP_TRACK,
        OP_TEST,
        OP_LOAD_TRACK,
        OP_LOAD_WAVE
    } op_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        op_t                op;
        logic signed [10:0] sample;
        logic [31:0]        angle_num;
        logic               angle_neg;
        logic signed [31:0] angle_value;
        logic signed [7:0]  percent;
        logic signed [10:0] wave;
        logic [9:0]         index;
    } cpc_item_t;

    typedef struct packed {
        logic signed [31:0] kp_current;
        logic signed [31:0] ki_current;
        logic signed [31:0] kp_position;
        logic signed [31:0] ki_position;
        logic signed [31:0] kd_position;
    } cpc_gains_t;

endpackage

`default_nettype wire

FILE: sv/cpc_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface cpc_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic [9:0]         adc_raw;
    logic [15:0]        encoder_count;
    logic signed [31:0] angle_value;
    logic signed [7:0]  open_loop_percent;
    logic signed [10:0] wave_value;
    logic [9:0]         entry_index;

    modport source (output valid, func, adc_raw, encoder_count, angle_value,
                    open_loop_percent, wave_value, entry_index, input ready);
    modport sink (input valid, func, adc_raw, encoder_count, angle_value,
                  open_loop_percent, wave_value, entry_index, output ready);
endinterface

interface cpc_out_if;
    logic               valid;
    logic               ready;
    logic [10:0]        duty;
    logic               direction;
    logic [2:0]         mode;
    logic signed [31:0] motor_angle;
    logic signed [10:0] current_sample;
    logic signed [25:0] current_command;
    logic               record_valid;

    modport source (output valid, duty, direction, mode, motor_angle, current_sample,
                    current_command, record_valid, input ready);
    modport sink (input valid, duty, direction, mode, motor_angle, current_sample,
                  current_command, record_valid, output ready);
endinterface

`default_nettype wire

FILE: sv/cpc_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
`default_nettype none

module cpc_front
    import cpc_pkg::*;
#(
    parameter int TRACK_DEPTH  = TRACK_DEPTH_DEF,
    parameter int TEST_SAMPLES = TEST_SAMPLES_DEF,
    parameter int DRIVE_LIMIT  = DRIVE_LIMIT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpc_in_if.sink    in_ch,
    input  wire logic pop,
    output logic      item_valid,
    output cpc_item_t item
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic signed [7:0] PCT_LIM = 8'(DRIVE_LIMIT);

    cpc_item_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]        count_reg, count_next;
    logic               push;
    logic               take;
    cpc_item_t          cls;
    logic signed [11:0] sample_wide;
    logic [15:0]        angle_mag;

    assign in_ch.ready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign item_valid  = (count_reg != '0);
    assign take        = pop && item_valid;
    assign item        = slot_reg[rd_ptr_reg];

    assign sample_wide = $signed({1'b0, in_ch.adc_raw, 1'b0}) - 12'sd1023;
    // Distance of the count from the zero-angle point, with the sign kept apart.
    assign angle_mag   = in_ch.encoder_count[15] ? (in_ch.encoder_count - 16'h8000)
                                                 : (16'h8000 - in_ch.encoder_count);

    always_comb
    begin
        cls.sample      = sample_wide[10:0];
        cls.angle_num   = {angle_mag, 16'd2};
        cls.angle_neg   = !in_ch.encoder_count[15];
        cls.angle_value = in_ch.angle_value;
        cls.wave        = in_ch.wave_value;
        cls.index       = in_ch.entry_index;
        if (in_ch.open_loop_percent > PCT_LIM)
            cls.percent = PCT_LIM;
        else if (in_ch.open_loop_percent < -PCT_LIM)
            cls.percent = -PCT_LIM;
        else
            cls.percent = in_ch.open_loop_percent;
        unique case (in_ch.func)
            FUNC_CURRENT_TICK:  cls.op = OP_CUR;
            FUNC_POSITION_TICK: cls.op = OP_POS;
            FUNC_IDLE:          cls.op = OP_IDLE;
            FUNC_OPEN_LOOP:     cls.op = OP_OPEN;
            FUNC_HOLD:          cls.op = OP_HOLD;
            FUNC_TRACK:         cls.op = OP_TRACK;
            FUNC_TEST:          cls.op = OP_TEST;
            FUNC_LOAD_TRACK:
                cls.op = (32'(in_ch.entry_index) < 32'(TRACK_DEPTH)) ? OP_LOAD_TRACK : OP_NOP;
            FUNC_LOAD_WAVE:
                cls.op = (32'(in_ch.entry_index) < 32'(TEST_SAMPLES)) ? OP_LOAD_WAVE : OP_NOP;
            default:            cls.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (take)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

FILE: sv/cpc_back.sv
// Back end: sequencer with one shared multiplier that runs both control loops.
`default_nettype none

module cpc_back
    import cpc_pkg::*;
#(
    parameter int TRACK_DEPTH   = TRACK_DEPTH_DEF,
    parameter int TEST_SAMPLES  = TEST_SAMPLES_DEF,
    parameter int CURRENT_LIMIT = CURRENT_LIMIT_DEF,
    parameter int DRIVE_LIMIT   = DRIVE_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire cpc_item_t   item,
    output logic             pop,
    input  wire cpc_gains_t  gains,
    input  wire logic [10:0] track_length,
    input  wire logic        clear_ci,
    cpc_out_if.source        out_ch
);

    localparam int TAW = $clog2(TRACK_DEPTH);
    localparam int TIW = $clog2(TRACK_DEPTH + 1);
    localparam int TXW = $clog2(TEST_SAMPLES);

    localparam logic signed [32:0] RECIP5  = 33'sh0CCCCCCCD;
    localparam logic signed [65:0] I48_MAX = 66'sh00000_7FFF_FFFF_FFFF;
    localparam logic signed [65:0] I48_MIN = ~I48_MAX;
    localparam logic signed [65:0] CMD_LIM = 66'(CURRENT_LIMIT * 65536);
    localparam logic signed [65:0] DRV_LIM = 66'(DRIVE_LIMIT * 65536);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_C1   = 4'd2;
    localparam logic [3:0] S_C2   = 4'd3;
    localparam logic [3:0] S_C3   = 4'd4;
    localparam logic [3:0] S_C4   = 4'd5;
    localparam logic [3:0] S_C5   = 4'd6;
    localparam logic [3:0] S_C6   = 4'd7;
    localparam logic [3:0] S_P1   = 4'd8;
    localparam logic [3:0] S_P2   = 4'd9;
    localparam logic [3:0] S_P3   = 4'd10;
    localparam logic [3:0] S_P4   = 4'd11;
    localparam logic [3:0] S_P5   = 4'd12;
    localparam logic [3:0] S_P6   = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v > I48_MAX) ? I48_MAX : ((v < I48_MIN) ? I48_MIN : v);
        return r[47:0];
    endfunction

    logic [3:0]         state_reg, state_next;
    cpc_item_t          cur_reg, cur_next;
    logic [2:0]         mode_reg, mode_next;
    logic signed [47:0] ci_reg, ci_next;
    logic signed [47:0] pi_reg, pi_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] hold_cmd_reg, hold_cmd_next;
    logic signed [31:0] track_cmd_reg, track_cmd_next;
    logic [10:0]        duty_reg, duty_next;
    logic               dir_reg, dir_next;
    logic [TIW-1:0]     track_idx_reg, track_idx_next;
    logic [TXW-1:0]     test_idx_reg, test_idx_next;
    logic               rec_reg, rec_next;
    logic signed [32:0] err_reg, err_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [31:0] angle_reg, angle_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    logic               out_valid_reg;
    logic [10:0]        o_duty_reg;
    logic               o_dir_reg;
    logic [2:0]         o_mode_reg;
    logic signed [31:0] o_angle_reg;
    logic signed [10:0] o_sample_reg;
    logic signed [25:0] o_cmd_reg;
    logic               o_rec_reg;
    logic               out_load;

    logic signed [31:0] track_mem [TRACK_DEPTH];
    logic signed [10:0] wave_mem [TEST_SAMPLES];
    logic signed [31:0] trd_reg;
    logic signed [10:0] wrd_reg;
    logic [TAW-1:0]     trd_addr;
    logic               twr_en, wwr_en;

    logic [TIW-1:0]     len;
    logic [TXW:0]       test_idx_inc;
    logic [29:0]        quot;
    logic signed [31:0] angle_v;
    logic signed [31:0] tgt;
    logic               run_pid;
    logic signed [32:0] cmd;
    logic signed [32:0] sample_q;
    logic signed [65:0] lim;
    logic signed [65:0] clamped;
    logic signed [65:0] mag;
    logic [7:0]         pct_mag;

    assign len = (32'(track_length) > 32'(TRACK_DEPTH)) ? TIW'(TRACK_DEPTH) : TIW'(track_length);
    assign trd_addr = (track_idx_reg < len) ? TAW'(track_idx_reg) : TAW'(len - TIW'(1));
    assign test_idx_inc = {1'b0, test_idx_reg} + (TXW+1)'(1);

    // Rounded angle: floor((|n|*65536 + 2) / 5) through the reciprocal of five.
    assign quot    = prod_reg[63:34];
    assign angle_v = cur_reg.angle_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

    assign sample_q = {{6{cur_reg.sample[10]}}, cur_reg.sample, 16'h0000};
    assign lim      = (state_reg == S_P6) ? CMD_LIM : DRV_LIM;
    assign clamped  = (acc_reg > lim) ? lim : ((acc_reg < -lim) ? -lim : acc_reg);
    assign mag      = clamped[65] ? -clamped : clamped;
    assign pct_mag  = cur_reg.percent[7] ? 8'(-cur_reg.percent) : 8'(cur_reg.percent);

    always_comb
    begin
        if (mode_reg == MODE_HOLD)
            cmd = {hold_cmd_reg[31], hold_cmd_reg};
        else if (mode_reg == MODE_TRACK)
            cmd = {track_cmd_reg[31], track_cmd_reg};
        else
            cmd = {{6{wrd_reg[10]}}, wrd_reg, 16'h0000};
    end

    always_comb
    begin
        run_pid = 1'b0;
        tgt     = target_reg;
        if (mode_reg == MODE_HOLD)
            run_pid = 1'b1;
        else if (mode_reg == MODE_TRACK && track_idx_reg < len)
        begin
            run_pid = 1'b1;
            tgt     = trd_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        mode_next      = mode_reg;
        ci_next        = ci_reg;
        pi_next        = pi_reg;
        prev_next      = prev_reg;
        target_next    = target_reg;
        hold_cmd_next  = hold_cmd_reg;
        track_cmd_next = track_cmd_reg;
        duty_next      = duty_reg;
        dir_next       = dir_reg;
        track_idx_next = track_idx_reg;
        test_idx_next  = test_idx_reg;
        rec_next       = rec_reg;
        err_next       = err_reg;
        d_next         = d_reg;
        angle_next     = angle_reg;
        acc_next       = acc_reg;
        mul_a          = '0;
        mul_b          = '0;
        pop            = 1'b0;
        twr_en         = 1'b0;
        wwr_en         = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pop        = 1'b1;
                    cur_next   = item;
                    rec_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cur_reg.op)
                    OP_CUR:
                    begin
                        if (mode_reg == MODE_HOLD || mode_reg == MODE_TRACK
                            || mode_reg == MODE_TEST)
                            state_next = S_C1;
                        else if (mode_reg == MODE_IDLE)
                            duty_next = '0;
                    end
                    OP_POS:
                    begin
                        mul_a      = {1'b0, cur_reg.angle_num};
                        mul_b      = RECIP5;
                        state_next = S_P1;
                    end
                    OP_IDLE:
                    begin
                        mode_next = MODE_IDLE;
                        duty_next = '0;
                        dir_next  = 1'b0;
                    end
                    OP_OPEN:
                    begin
                        mode_next = MODE_OPEN;
                        duty_next = 11'(pct_mag) * 11'd20;
                        dir_next  = !cur_reg.percent[7];
                    end
                    OP_HOLD:
                    begin
                        target_next = cur_reg.angle_value;
                        pi_next     = '0;
                        mode_next   = MODE_HOLD;
                    end
                    OP_TRACK:
                    begin
                        pi_next        = '0;
                        ci_next        = '0;
                        track_idx_next = '0;
                        mode_next      = MODE_TRACK;
                    end
                    OP_TEST:
                    begin
                        test_idx_next = '0;
                        mode_next     = MODE_TEST;
                    end
                    OP_LOAD_TRACK: twr_en = 1'b1;
                    OP_LOAD_WAVE:  wwr_en = 1'b1;
                    default: ;
                endcase
            end
            S_C1:
            begin
                err_next   = sample_q - cmd;
                state_next = S_C2;
            end
            S_C2:
            begin
                ci_next    = sat48(66'(ci_reg) + 66'(err_reg));
                mul_a      = {gains.kp_current[31], gains.kp_current};
                mul_b      = err_reg;
                state_next = S_C3;
            end
            S_C3:
            begin
                acc_next   = prod_reg >>> 16;
                mul_a      = {gains.ki_current[31], gains.ki_current};
                mul_b      = {ci_reg[47], ci_reg[47:16]};
                state_next = S_C4;
            end
            S_C4:
            begin
                acc_next   = acc_reg + prod_reg;
                mul_a      = {gains.ki_current[31], gains.ki_current};
                mul_b      = {17'd0, ci_reg[15:0]};
                state_next = S_C5;
            end
            S_C5:
            begin
                acc_next   = acc_reg + (prod_reg >>> 16);
                state_next = S_C6;
            end
            S_C6:
            begin
                duty_next  = 11'(mag[22:16]) * 11'd20;
                dir_next   = clamped[65];
                state_next = S_DONE;
                if (mode_reg == MODE_TEST)
                begin
                    rec_next = 1'b1;
                    // The run ends on the tick that uses the last waveform sample.
                    if (test_idx_inc == (TXW+1)'(TEST_SAMPLES))
                    begin
                        test_idx_next = '0;
                        mode_next     = MODE_IDLE;
                    end
                    else
                        test_idx_next = test_idx_inc[TXW-1:0];
                end
            end
            S_P1:
            begin
                angle_next = angle_v;
                state_next = S_DONE;
                if (run_pid)
                begin
                    err_next   = {angle_v[31], angle_v} - {tgt[31], tgt};
                    d_next     = {angle_v[31], angle_v} - {prev_reg[31], prev_reg};
                    prev_next  = angle_v;
                    rec_next   = (mode_reg == MODE_TRACK);
                    state_next = S_P2;
                end
                else if (mode_reg == MODE_TRACK)
                begin
                    // Table exhausted: settle on the last entry, if the table has one, and hold there.
                    track_idx_next = '0;
                    pi_next        = '0;
                    mode_next      = MODE_HOLD;
                    if (len != '0)
                    begin
                        target_next = trd_reg;
                        prev_next   = trd_reg;
                    end
                    else
                        prev_next = target_reg;
                end
            end
            S_P2:
            begin
                mul_a      = {gains.ki_position[31], gains.ki_position};
                mul_b      = err_reg;
                state_next = S_P3;
            end
            S_P3:
            begin
                pi_next    = sat48(66'(pi_reg) + (prod_reg >>> 16));
                mul_a      = {gains.kp_position[31], gains.kp_position};
                mul_b      = err_reg;
                state_next = S_P4;
            end
            S_P4:
            begin
                acc_next   = (prod_reg >>> 16) + 66'(pi_reg);
                mul_a      = {gains.kd_position[31], gains.kd_position};
                mul_b      = d_reg;
                state_next = S_P5;
            end
            S_P5:
            begin
                acc_next   = acc_reg + (prod_reg >>> 16);
                state_next = S_P6;
            end
            S_P6:
            begin
                state_next = S_DONE;
                if (mode_reg == MODE_HOLD)
                    hold_cmd_next = clamped[31:0];
                else
                begin
                    track_cmd_next = clamped[31:0];
                    track_idx_next = track_idx_reg + TIW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (clear_ci)
            ci_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_IDLE;
            ci_reg        <= '0;
            pi_reg        <= '0;
            prev_reg      <= '0;
            target_reg    <= '0;
            hold_cmd_reg  <= '0;
            track_cmd_reg <= '0;
            duty_reg      <= '0;
            dir_reg       <= 1'b0;
            track_idx_reg <= '0;
            test_idx_reg  <= '0;
            rec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ci_reg        <= ci_next;
            pi_reg        <= pi_next;
            prev_reg      <= prev_next;
            target_reg    <= target_next;
            hold_cmd_reg  <= hold_cmd_next;
            track_cmd_reg <= track_cmd_next;
            duty_reg      <= duty_next;
            dir_reg       <= dir_next;
            track_idx_reg <= track_idx_next;
            test_idx_reg  <= test_idx_next;
            rec_reg       <= rec_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        err_reg   <= err_next;
        d_reg     <= d_next;
        angle_reg <= angle_next;
        acc_reg   <= acc_next;
        prod_reg  <= mul_a * mul_b;
        if (out_load)
        begin
            o_duty_reg   <= duty_reg;
            o_dir_reg    <= dir_reg;
            o_mode_reg   <= mode_reg;
            o_angle_reg  <= (cur_reg.op == OP_POS) ? angle_reg : '0;
            o_sample_reg <= (cur_reg.op == OP_CUR) ? cur_reg.sample : '0;
            o_rec_reg    <= rec_reg;
            if (mode_reg == MODE_HOLD)
                o_cmd_reg <= hold_cmd_reg[25:0];
            else if (mode_reg == MODE_TRACK)
                o_cmd_reg <= track_cmd_reg[25:0];
            else
                o_cmd_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (twr_en)
            track_mem[TAW'(cur_reg.index)] <= cur_reg.angle_value;
        trd_reg <= track_mem[trd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wwr_en)
            wave_mem[TXW'(cur_reg.index)] <= cur_reg.wave;
        wrd_reg <= wave_mem[test_idx_reg];
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.duty            = o_duty_reg;
    assign out_ch.direction       = o_dir_reg;
    assign out_ch.mode            = o_mode_reg;
    assign out_ch.motor_angle     = o_angle_reg;
    assign out_ch.current_sample  = o_sample_reg;
    assign out_ch.current_command = o_cmd_reg;
    assign out_ch.record_valid    = o_rec_reg;

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= 11'(DRIVE_LIMIT * 20))
        else $error("drive duty above its limit");

    a_test_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, test_idx_reg} < (TXW+1)'(TEST_SAMPLES))
        else $error("waveform index past the table");

    a_pos_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P1) |-> ($past(state_reg) == S_EXEC && cur_reg.op == OP_POS))
        else $error("position step entered out of sequence");

    a_cur_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C1) |-> ($past(state_reg) == S_EXEC && cur_reg.op == OP_CUR))
        else $error("current step entered out of sequence");

endmodule

`default_nettype wire

FILE: sv/cascaded_position_current_controller.sv
// Top level: configuration registers, front end and back end of the controller.
//
//  channel   direction  handshake                    carries
//  in_ch     in         valid/ready                  command or tick item
//  out_ch    out        valid/ready                  one status item per input item
//  APB       in         psel/penable/pwrite, pready  gains and track length
//
// A current tick in hold, track or test mode and a position tick in hold mode, or in track
// mode with table entries left, step through the back-end sequencer's loop states, which run
// each loop's products through one shared 33x33 multiplier.
// A two-entry queue accepts items while the back end works or a result waits.
// Reset loads the default gains and clears modes, integrals and indices; the tables
// hold whatever was last loaded and need no clearing pass.

`default_nettype none

module cascaded_position_current_controller
    import cpc_pkg::*;
#(
    parameter int TRACK_DEPTH   = TRACK_DEPTH_DEF,
    parameter int TEST_SAMPLES  = TEST_SAMPLES_DEF,
    parameter int CURRENT_LIMIT = CURRENT_LIMIT_DEF,
    parameter int DRIVE_LIMIT   = DRIVE_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cpc_in_if.sink           in_ch,
    cpc_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cpc_gains_t  gains_reg;
    logic [10:0] track_len_reg;
    logic [2:0]  reg_index;
    logic        wr;
    logic        clear_ci;
    logic        pop;
    logic        item_valid;
    cpc_item_t   item;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr        = psel && penable && pwrite && pready;
    // Any gain write restarts the current loop integral.
    assign clear_ci  = wr && (reg_index <= REG_KD_POSITION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.kp_current  <= KP_CURRENT_RST;
            gains_reg.ki_current  <= KI_CURRENT_RST;
            gains_reg.kp_position <= KP_POSITION_RST;
            gains_reg.ki_position <= KI_POSITION_RST;
            gains_reg.kd_position <= KD_POSITION_RST;
            track_len_reg         <= '0;
        end
        else if (wr)
        begin
            unique case (reg_index)
                REG_KP_CURRENT:   gains_reg.kp_current  <= pwdata;
                REG_KI_CURRENT:   gains_reg.ki_current  <= pwdata;
                REG_KP_POSITION:  gains_reg.kp_position <= pwdata;
                REG_KI_POSITION:  gains_reg.ki_position <= pwdata;
                REG_KD_POSITION:  gains_reg.kd_position <= pwdata;
                REG_TRACK_LENGTH: track_len_reg         <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_KP_CURRENT:   prdata = gains_reg.kp_current;
            REG_KI_CURRENT:   prdata = gains_reg.ki_current;
            REG_KP_POSITION:  prdata = gains_reg.kp_position;
            REG_KI_POSITION:  prdata = gains_reg.ki_position;
            REG_KD_POSITION:  prdata = gains_reg.kd_position;
            REG_TRACK_LENGTH: prdata = {21'd0, track_len_reg};
            default:          prdata = '0;
        endcase
    end

    cpc_front #(
        .TRACK_DEPTH  (TRACK_DEPTH),
        .TEST_SAMPLES (TEST_SAMPLES),
        .DRIVE_LIMIT  (DRIVE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    cpc_back #(
        .TRACK_DEPTH   (TRACK_DEPTH),
        .TEST_SAMPLES  (TEST_SAMPLES),
        .CURRENT_LIMIT (CURRENT_LIMIT),
        .DRIVE_LIMIT   (DRIVE_LIMIT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .pop          (pop),
        .gains        (gains_reg),
        .track_length (track_len_reg),
        .clear_ci     (clear_ci),
        .out_ch       (out_ch)
    );

endmodule

`default_nettype wire

FILE: sim/cpc_checker.sv
// Result checker: watches both channels, predicts each status item and compares it.
module cpc_checker
    import cpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cpc_in_if.sink    in_mon,
    cpc_out_if.sink   out_mon,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q = 65536;
    localparam longint INT48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint INT48_MIN = -INT48_MAX - 1;

    typedef struct {
        logic [10:0]        duty;
        logic               direction;
        logic [2:0]         mode;
        logic signed [31:0] motor_angle;
        logic signed [10:0] current_sample;
        logic signed [25:0] current_command;
        logic               record_valid;
    } status_t;

    status_t status_q[$];

    longint kp_cur, ki_cur, kp_pos, ki_pos, kd_pos;
    int unsigned trk_len;
    logic [2:0] run_mode;
    longint cur_int, pos_int, prev_angle, target, hold_cmd, trk_cmd;
    int unsigned duty_r, dir_r, trk_idx, test_idx;
    longint trk_table[TRACK_DEPTH_DEF];
    longint wave_table[TEST_SAMPLES_DEF];

    function automatic longint floor16(longint v);
        if (v >= 0)
            return v / ONE_Q;
        return -((-v + ONE_Q - 1) / ONE_Q);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint count_to_angle(logic [15:0] cnt);
        longint n, q, r;
        n = (longint'(cnt) - 32768) * ONE_Q;
        q = n / 5;
        r = n - q * 5;
        if (r >= 3)
            q++;
        else if (r <= -3)
            q--;
        return q;
    endfunction

    function automatic longint position_loop(longint ang, longint tgt);
        longint err, c;
        err = ang - tgt;
        pos_int = clip(pos_int + floor16(ki_pos * err), INT48_MIN, INT48_MAX);
        c = floor16(kp_pos * err) + pos_int + floor16(kd_pos * (ang - prev_angle));
        prev_angle = ang;
        return clip(c, -CURRENT_LIMIT_DEF * ONE_Q, CURRENT_LIMIT_DEF * ONE_Q);
    endfunction

    task automatic current_loop(longint smp, longint cmd);
        longint err, hi, lo, u;
        err = smp * ONE_Q - cmd;
        cur_int = clip(cur_int + err, INT48_MIN, INT48_MAX);
        hi = floor16(cur_int);
        lo = cur_int - hi * ONE_Q;
        u = floor16(kp_cur * err) + ki_cur * hi + floor16(ki_cur * lo);
        u = clip(u, -DRIVE_LIMIT_DEF * ONE_Q, DRIVE_LIMIT_DEF * ONE_Q);
        duty_r = int'((u < 0 ? -u : u) / ONE_Q) * 20;
        dir_r = u < 0;
    endtask

    // Called by the testbench top when a register write lands.
    function automatic void write_gain(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_KP_CURRENT:   kp_cur = longint'($signed(val));
            REG_KI_CURRENT:   ki_cur = longint'($signed(val));
            REG_KP_POSITION:  kp_pos = longint'($signed(val));
            REG_KI_POSITION:  ki_pos = longint'($signed(val));
            REG_KD_POSITION:  kd_pos = longint'($signed(val));
            REG_TRACK_LENGTH: trk_len = val[10:0];
            default: ;
        endcase
        if (idx != REG_TRACK_LENGTH)
            cur_int = 0;
    endfunction

    task automatic predict_status();
        status_t s;
        longint ang, smp, cmd, p;
        int unsigned len;
        s = '{default: '0};
        len = trk_len > TRACK_DEPTH_DEF ? TRACK_DEPTH_DEF : trk_len;
        ang = 0;
        smp = 0;
        case (in_mon.func)
            FUNC_CURRENT_TICK: begin
                smp = 2 * longint'(in_mon.adc_raw) - 1023;
                case (run_mode)
                    MODE_IDLE:  duty_r = 0;
                    MODE_HOLD:  current_loop(smp, hold_cmd);
                    MODE_TRACK: current_loop(smp, trk_cmd);
                    MODE_TEST:
                    begin
                        if (test_idx >= TEST_SAMPLES_DEF)
                            test_idx = 0;
                        current_loop(smp, wave_table[test_idx] * ONE_Q);
                        s.record_valid = 1;
                        test_idx++;
                        if (test_idx >= TEST_SAMPLES_DEF)
                        begin
                            test_idx = 0;
                            run_mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_POSITION_TICK: begin
                ang = count_to_angle(in_mon.encoder_count);
                if (run_mode == MODE_HOLD)
                    hold_cmd = position_loop(ang, target);
                else if (run_mode == MODE_TRACK)
                begin
                    if (trk_idx < len)
                    begin
                        trk_cmd = position_loop(ang, trk_table[trk_idx]);
                        s.record_valid = 1;
                        trk_idx++;
                    end
                    else
                    begin
                        trk_idx = 0;
                        if (len > 0)
                            target = trk_table[len - 1];
                        pos_int = 0;
                        prev_angle = target;
                        run_mode = MODE_HOLD;
                    end
                end
            end
            FUNC_IDLE: begin
                run_mode = MODE_IDLE;
                duty_r = 0;
                dir_r = 0;
            end
            FUNC_OPEN_LOOP: begin
                p = clip(longint'(in_mon.open_loop_percent), -DRIVE_LIMIT_DEF, DRIVE_LIMIT_DEF);
                run_mode = MODE_OPEN;
                duty_r = int'(p < 0 ? -p : p) * 20;
                dir_r = p >= 0;
            end
            FUNC_HOLD: begin
                target = longint'(in_mon.angle_value);
                pos_int = 0;
                run_mode = MODE_HOLD;
            end
            FUNC_TRACK: begin
                pos_int = 0;
                cur_int = 0;
                trk_idx = 0;
                run_mode = MODE_TRACK;
            end
            FUNC_TEST: begin
                test_idx = 0;
                run_mode = MODE_TEST;
            end
            FUNC_LOAD_TRACK:
                trk_table[in_mon.entry_index] = longint'(in_mon.angle_value);
            FUNC_LOAD_WAVE:
                if (in_mon.entry_index < TEST_SAMPLES_DEF)
                    wave_table[in_mon.entry_index] = longint'(in_mon.wave_value);
            default: ;
        endcase
        cmd = run_mode == MODE_HOLD ? hold_cmd : (run_mode == MODE_TRACK ? trk_cmd : 0);
        s.duty = duty_r[10:0];
        s.direction = dir_r[0];
        s.mode = run_mode;
        s.motor_angle = ang[31:0];
        s.current_sample = smp[10:0];
        s.current_command = cmd[25:0];
        status_q.push_back(s);
    endtask

    task automatic report(string fld, longint exp_v, longint act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", fld, exp_v, act_v);
    endtask

    task automatic compare_status();
        status_t e;
        if (status_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("status item with nothing expected");
            return;
        end
        e = status_q.pop_front();
        if (out_mon.duty !== e.duty) report("duty", e.duty, out_mon.duty);
        if (out_mon.direction !== e.direction) report("direction", e.direction, out_mon.direction);
        if (out_mon.mode !== e.mode) report("mode", e.mode, out_mon.mode);
        if (out_mon.motor_angle !== e.motor_angle)
            report("motor_angle", e.motor_angle, out_mon.motor_angle);
        if (out_mon.current_sample !== e.current_sample)
            report("current_sample", e.current_sample, out_mon.current_sample);
        if (out_mon.current_command !== e.current_command)
            report("current_command", e.current_command, out_mon.current_command);
        if (out_mon.record_valid !== e.record_valid)
            report("record_valid", e.record_valid, out_mon.record_valid);
    endtask

    initial
    begin
        fail_count = 0;
        kp_cur = longint'($signed(KP_CURRENT_RST));
        ki_cur = longint'($signed(KI_CURRENT_RST));
        kp_pos = longint'($signed(KP_POSITION_RST));
        ki_pos = longint'($signed(KI_POSITION_RST));
        kd_pos = longint'($signed(KD_POSITION_RST));
        trk_len = 0;
        run_mode = MODE_IDLE;
        cur_int = 0;
        pos_int = 0;
        prev_angle = 0;
        target = 0;
        hold_cmd = 0;
        trk_cmd = 0;
        duty_r = 0;
        dir_r = 0;
        trk_idx = 0;
        test_idx = 0;
        foreach (trk_table[i]) trk_table[i] = 0;
        foreach (wave_table[i]) wave_table[i] = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_mon.valid && in_mon.ready)
                predict_status();
            if (out_mon.valid && out_mon.ready)
                compare_status();
        end
    end

    assign pending_count = status_q.size();
endmodule

FILE: sim/tb_cascaded_position_current_controller.sv
// Testbench top: drives items and register writes, and gives the verdict.
module tb_cascaded_position_current_controller;
    import cpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    int fails, pending, cycles;
    bit long_stall;
    bit wave_ok[TEST_SAMPLES_DEF];

    cpc_in_if in_ch();
    cpc_out_if out_ch();

    cascaded_position_current_controller dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cpc_checker chk (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
        .fail_count(fails), .pending_count(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** cascaded_position_current_controller: FAILED **");
            $finish;
        end
    end

    // Receiver: random stall per item, with one long hold-off on request.
    initial
    begin : receiver
        int gap;
        out_ch.ready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall)
            begin
                out_ch.ready <= 0;
                repeat (200) @(posedge clk);
                long_stall = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            out_ch.ready <= 0;
        end
    end

    // Valid stays high after an item is taken; the next gap or drain() lowers it.
    task automatic send(logic [3:0] f, logic [9:0] adc, logic [15:0] enc, logic [31:0] ang,
                        logic [7:0] pct, logic [10:0] wav, logic [9:0] idx, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= f;
        in_ch.adc_raw <= adc;
        in_ch.encoder_count <= enc;
        in_ch.angle_value <= ang;
        in_ch.open_loop_percent <= pct;
        in_ch.wave_value <= wav;
        in_ch.entry_index <= idx;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_rand(logic [3:0] f);
        logic [9:0] idx;
        idx = 10'($urandom);
        // Loads may hit any index; a wave load inside the table marks that entry as written.
        if (f == FUNC_LOAD_WAVE && idx < TEST_SAMPLES_DEF) wave_ok[idx] = 1;
        send(f, 10'($urandom), 16'($urandom), $urandom, 8'($urandom), 11'($urandom), idx);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] r, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        chk.write_gain(r, val);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic load_all();
        for (int i = 0; i < TEST_SAMPLES_DEF; i++)
        begin
            send(FUNC_LOAD_WAVE, 0, 0, 0, 0, 11'($signed($urandom_range(0, 2046)) - 1023),
                 10'(i), 1);
            wave_ok[i] = 1;
        end
        for (int i = 0; i < 40; i++)
            send(FUNC_LOAD_TRACK, 0, 0, $urandom, 0, 0, 10'(i), 1);
    endtask

    // A well-formed control sequence: enter a mode, then a mix of ticks.
    task automatic run_sequence(int n);
        logic [3:0] f;
        logic [3:0] m;
        m = 4'($urandom_range(2, 6));
        if (m == FUNC_TEST && !wave_ok[0]) m = FUNC_HOLD;
        send(m, 0, 0, $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 200000)) - 100000),
             8'($urandom), 0, 0);
        for (int i = 0; i < n; i++)
        begin
            f = 4'($urandom_range(0, 1));
            send(f, 10'($urandom),
                 16'($urandom_range(0, 1) ? $urandom : (32768 + $urandom_range(0, 200) - 100)),
                 0, 0, 0, 0);
        end
    endtask

    initial
    begin
        int rsel;
        rst_n = 0;
        cycles = 0;
        long_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.func = 0; in_ch.adc_raw = 0; in_ch.encoder_count = 0;
        in_ch.angle_value = 0; in_ch.open_loop_percent = 0; in_ch.wave_value = 0;
        in_ch.entry_index = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: extremes, every func code and the special cases.
        send(FUNC_CURRENT_TICK, 10'd0, 0, 0, 0, 0, 0);
        send(FUNC_CURRENT_TICK, 10'd1023, 0, 0, 0, 0, 0);
        send(FUNC_POSITION_TICK, 0, 16'h0000, 0, 0, 0, 0);
        send(FUNC_POSITION_TICK, 0, 16'hFFFF, 0, 0, 0, 0);
        send(FUNC_OPEN_LOOP, 0, 0, 0, 8'sd127, 0, 0);
        send(FUNC_OPEN_LOOP, 0, 0, 0, -8'sd128, 0, 0);
        send(FUNC_OPEN_LOOP, 0, 0, 0, 8'sd0, 0, 0);
        send(FUNC_CURRENT_TICK, 10'd512, 0, 0, 0, 0, 0);
        send(FUNC_IDLE, 0, 0, 0, 0, 0, 0);
        send(4'd9, 0, 0, 0, 0, 0, 0);
        send(4'd15, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 11'h7FF, 10'h3FF);
        send(FUNC_LOAD_WAVE, 0, 0, 0, 0, 11'sd1023, 10'd1023);
        send(FUNC_LOAD_WAVE, 0, 0, 0, 0, -11'sd1023, 10'd100);
        send(FUNC_HOLD, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
        send(FUNC_POSITION_TICK, 0, 16'h0000, 0, 0, 0, 0);
        send(FUNC_CURRENT_TICK, 10'd0, 0, 0, 0, 0, 0);
        send(FUNC_HOLD, 0, 0, 32'h8000_0000, 0, 0, 0);
        send(FUNC_POSITION_TICK, 0, 16'hFFFF, 0, 0, 0, 0);
        send(FUNC_CURRENT_TICK, 10'd1023, 0, 0, 0, 0, 0);
        send(FUNC_TRACK, 0, 0, 0, 0, 0, 0);
        send(FUNC_POSITION_TICK, 0, 16'd32768, 0, 0, 0, 0);
        drain();

        load_all();
        drain();
        reg_write(REG_TRACK_LENGTH, 32'd3);
        send(FUNC_TRACK, 0, 0, 0, 0, 0, 0);
        repeat (5) send(FUNC_POSITION_TICK, 0, 16'($urandom), 0, 0, 0, 0);
        send(FUNC_TEST, 0, 0, 0, 0, 0, 0);
        repeat (102) send(FUNC_CURRENT_TICK, 10'($urandom), 0, 0, 0, 0, 0, 1);
        drain();

        // Random phases under several register settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: ;
                1: begin
                    reg_write(REG_KP_CURRENT, 32'h7FFF_FFFF);
                    reg_write(REG_KI_CURRENT, 32'h8000_0000);
                    reg_write(REG_TRACK_LENGTH, 32'd2047);
                end
                2: begin
                    reg_write(REG_KP_POSITION, 32'h8000_0000);
                    reg_write(REG_KI_POSITION, 32'h7FFF_FFFF);
                    reg_write(REG_KD_POSITION, 32'h0);
                    reg_write(REG_TRACK_LENGTH, 32'd0);
                end
                default: begin
                    reg_write(REG_KP_CURRENT, $urandom_range(0, 200000));
                    reg_write(REG_KI_CURRENT, $urandom);
                    reg_write(REG_KP_POSITION, $urandom_range(0, 3000000));
                    reg_write(REG_KI_POSITION, $urandom_range(0, 2000));
                    reg_write(REG_KD_POSITION, $urandom);
                    reg_write(REG_TRACK_LENGTH, $urandom_range(0, 40));
                end
            endcase
            if (ph == 3)
                long_stall = 1;
            for (int k = 0; k < 75; )
            begin
                rsel = $urandom_range(0, 9);
                if (rsel < 7)
                begin
                    run_sequence($urandom_range(3, 12));
                    k += 8;
                end
                else
                begin
                    rsel = $urandom_range(0, 8);
                    if (rsel != FUNC_TEST || wave_ok[0])
                        send_rand(4'(rsel));
                    k++;
                end
            end
            drain();
        end

        if (fails == 0)
            $display("** cascaded_position_current_controller: PASSED **");
        else
            $display("** cascaded_position_current_controller: FAILED **");
        $finish;
    end
endmodule
